// ===== src/lsact_pkg.sv =====
// shared types, constants and helpers of the cache tag store
`timescale 1ns / 1ps
`default_nettype none
package lsact_pkg;

    localparam int ADDR_W    = 48;
    localparam int TAG_W     = 48;
    localparam int STAMP_W   = 32;
    localparam int TOTAL_W   = 32;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 5;
    localparam int LINE_W    = 1 + TAG_W + STAMP_W;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STORE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FETCH  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd2;

    // effective geometry after clamping
    typedef struct packed {
        logic [2:0] set_bits;
        logic [4:0] ways;
        logic [4:0] block_bits;
    } t_geom;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_EVICT
    } t_state;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v,
                                                   input logic en);
        logic [TOTAL_W-1:0] r;
        r = v;
        if (en && (v != {TOTAL_W{1'b1}})) begin
            r = v + TOTAL_W'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/lsact_if.sv =====
// channel interfaces: access words in, result words out, configuration writes
`timescale 1ns / 1ps
`default_nettype none
interface lsact_in_if;
    logic                        valid;
    logic                        ready;
    logic [lsact_pkg::MODE_W-1:0] mode;
    logic [lsact_pkg::ADDR_W-1:0] address;
    modport source (output valid, output mode, output address, input ready);
    modport sink   (input valid, input mode, input address, output ready);
endinterface

interface lsact_out_if;
    logic                          valid;
    logic                          ready;
    logic                          was_hit;
    logic                          was_miss;
    logic                          was_evict;
    logic [lsact_pkg::TOTAL_W-1:0] hit_total;
    logic [lsact_pkg::TOTAL_W-1:0] miss_total;
    logic [lsact_pkg::TOTAL_W-1:0] evict_total;
    modport source (output valid, output was_hit, output was_miss, output was_evict,
                    output hit_total, output miss_total, output evict_total, input ready);
    modport sink   (input valid, input was_hit, input was_miss, input was_evict,
                    input hit_total, input miss_total, input evict_total, output ready);
endinterface

interface lsact_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lsact_pkg::CFG_IDX_W-1:0] index;
    logic [lsact_pkg::CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/lsact_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module lsact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== src/lsact_queue.sv =====
// two entry queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module lsact_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_nonempty,
    output logic      [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_data [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_data     = r_data[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_data;
        end
    end
endmodule
`default_nettype wire

// ===== src/lsact_front.sv =====
// front: accepts access words, drops fetches, splits address into set and tag
`timescale 1ns / 1ps
`default_nettype none
module lsact_front #(
    parameter int SET_W = 6
) (
    lsact_in_if.sink                          i_in,
    input  wire lsact_pkg::t_geom              i_geom,
    input  wire lsact_pkg::t_back_status       i_status,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output logic [1+SET_W+lsact_pkg::TAG_W-1:0] o_entry
);
    logic [lsact_pkg::ADDR_W-1:0] w_shifted;
    logic [9:0]                   w_mask;
    logic [5:0]                   w_tag_sh;
    logic [SET_W-1:0]             w_set;
    logic [lsact_pkg::TAG_W-1:0]  w_tag;
    logic                         w_mod;

    assign i_in.ready = !i_status.clearing && !i_q_full;
    assign o_push     = i_in.valid && i_in.ready && (i_in.mode != lsact_pkg::MODE_FETCH);

    always_comb begin
        w_shifted = i_in.address >> i_geom.block_bits;
        w_mask    = (10'd1 << i_geom.set_bits) - 10'd1;
        w_set     = w_shifted[SET_W-1:0] & w_mask[SET_W-1:0];
        w_tag_sh  = {1'b0, i_geom.block_bits} + {3'b000, i_geom.set_bits};
        w_tag     = i_in.address >> w_tag_sh;
        w_mod     = (i_in.mode == lsact_pkg::MODE_MODIFY);
        o_entry   = {w_mod, w_set, w_tag};
    end
endmodule
`default_nettype wire

// ===== src/lsact_back.sv =====
// back: reads a set row, resolves hit or victim, writes the row back, keeps totals
`timescale 1ns / 1ps
`default_nettype none
module lsact_back #(
    parameter int SET_W    = 6,
    parameter int MAX_WAYS = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire lsact_pkg::t_geom                 i_geom,
    input  wire logic                             i_q_nonempty,
    input  wire logic [1+SET_W+lsact_pkg::TAG_W-1:0] i_q_data,
    output logic                                  o_pop,
    output lsact_pkg::t_back_status               o_status,
    lsact_out_if.source                           o_out
);
    localparam int ROWS  = 1 << SET_W;
    localparam int ROW_W = MAX_WAYS * lsact_pkg::LINE_W;
    localparam int WI_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TW    = lsact_pkg::TAG_W;
    localparam int SW    = lsact_pkg::STAMP_W;

    lsact_pkg::t_state r_state, n_state;

    logic [SET_W-1:0]            r_cnt;
    logic [SET_W-1:0]            r_set;
    logic [TW-1:0]               r_tag;
    logic                        r_mod;
    logic [WI_W-1:0]             r_vict, n_vict;
    logic [WI_W-1:0]             r_scan;
    logic [SW-1:0]               r_clock;
    logic [lsact_pkg::TOTAL_W-1:0] r_hits, r_miss, r_evic;
    logic                        r_ov;
    logic                        r_o_hit, r_o_evict;

    logic [ROW_W-1:0]            w_rdata;
    logic [ROW_W-1:0]            w_wdata;
    logic [SET_W-1:0]            w_waddr;
    logic                        w_we;
    logic                        w_re;
    logic                        w_issue;
    logic                        w_finish;
    logic                        w_hit, w_inv, w_evict, w_last;
    logic [WI_W-1:0]             w_hit_way, w_inv_way, w_sel_way;
    logic [SW-1:0]               w_clock_n;
    logic [SW-1:0]               w_st_scan, w_st_vict;
    logic [lsact_pkg::TOTAL_W-1:0] w_h1;

    lsact_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (i_q_data[TW +: SET_W]),
        .o_rdata (w_rdata)
    );

    assign o_status.clearing = (r_state == lsact_pkg::ST_CLEAR);
    assign w_clock_n = r_clock + SW'(1);
    assign w_issue   = (r_state == lsact_pkg::ST_IDLE) && i_q_nonempty
                       && (!r_ov || o_out.ready);
    assign o_pop     = w_issue;
    assign w_re      = w_issue;
    assign w_last    = ({{(5 - WI_W > 0 ? 5 - WI_W : 0){1'b0}}, r_scan} + 5'd1)
                       >= i_geom.ways;

    // hit and first invalid way among the ways in use
    always_comb begin
        w_hit     = 1'b0;
        w_inv     = 1'b0;
        w_hit_way = '0;
        w_inv_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (w < int'(i_geom.ways)) begin
                if (w_rdata[w*lsact_pkg::LINE_W + SW + TW]
                    && (w_rdata[w*lsact_pkg::LINE_W + SW +: TW] == r_tag)) begin
                    w_hit     = 1'b1;
                    w_hit_way = WI_W'(w);
                end
                if (!w_rdata[w*lsact_pkg::LINE_W + SW + TW]) begin
                    w_inv     = 1'b1;
                    w_inv_way = WI_W'(w);
                end
            end
        end
        w_st_scan = w_rdata[r_scan*lsact_pkg::LINE_W +: SW];
        w_st_vict = w_rdata[r_vict*lsact_pkg::LINE_W +: SW];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsact_pkg::ST_CLEAR: begin
                if (r_cnt == {SET_W{1'b1}}) begin
                    n_state = lsact_pkg::ST_IDLE;
                end
            end
            lsact_pkg::ST_IDLE: begin
                if (w_issue) begin
                    n_state = lsact_pkg::ST_LOOK;
                end
            end
            lsact_pkg::ST_LOOK: begin
                if (w_hit || w_inv) begin
                    n_state = lsact_pkg::ST_IDLE;
                end else if (i_geom.ways == 5'd1) begin
                    n_state = lsact_pkg::ST_EVICT;
                end else begin
                    n_state = lsact_pkg::ST_SCAN;
                end
            end
            lsact_pkg::ST_SCAN: begin
                if (w_last) begin
                    n_state = lsact_pkg::ST_EVICT;
                end
            end
            lsact_pkg::ST_EVICT: n_state = lsact_pkg::ST_IDLE;
            default:             n_state = lsact_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_set;
        w_wdata   = w_rdata;
        w_finish  = 1'b0;
        w_evict   = 1'b0;
        w_sel_way = r_vict;
        n_vict    = r_vict;
        unique case (r_state)
            lsact_pkg::ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt;
                w_wdata = '0;
            end
            lsact_pkg::ST_LOOK: begin
                n_vict = '0;
                if (w_hit || w_inv) begin
                    w_finish  = 1'b1;
                    w_sel_way = w_hit ? w_hit_way : w_inv_way;
                end
            end
            lsact_pkg::ST_SCAN: begin
                // lowest way wins a stamp tie
                if (w_st_scan < w_st_vict) begin
                    n_vict = r_scan;
                end
            end
            lsact_pkg::ST_EVICT: begin
                w_finish = 1'b1;
                w_evict  = 1'b1;
            end
            default: begin
            end
        endcase
        if (w_finish) begin
            w_we = 1'b1;
            w_wdata[w_sel_way*lsact_pkg::LINE_W +: lsact_pkg::LINE_W] =
                {1'b1, r_tag, w_clock_n};
        end
    end

    assign w_h1 = lsact_pkg::sat_inc(r_hits, w_hit && !w_evict);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsact_pkg::ST_CLEAR;
            r_cnt   <= '0;
            r_clock <= '0;
            r_hits  <= '0;
            r_miss  <= '0;
            r_evic  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lsact_pkg::ST_CLEAR) begin
                r_cnt <= r_cnt + SET_W'(1);
            end
            if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (w_finish) begin
                r_clock <= w_clock_n;
                r_hits  <= lsact_pkg::sat_inc(w_h1, r_mod);
                r_miss  <= lsact_pkg::sat_inc(r_miss, w_evict || !w_hit);
                r_evic  <= lsact_pkg::sat_inc(r_evic, w_evict);
                r_ov    <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_set <= i_q_data[TW +: SET_W];
            r_tag <= i_q_data[TW-1:0];
            r_mod <= i_q_data[TW+SET_W];
        end
        r_vict <= n_vict;
        if (r_state == lsact_pkg::ST_LOOK) begin
            r_scan <= WI_W'(1);
        end else if (r_state == lsact_pkg::ST_SCAN) begin
            r_scan <= r_scan + WI_W'(1);
        end
        if (w_finish) begin
            r_o_hit   <= w_hit && !w_evict;
            r_o_evict <= w_evict;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.was_hit     = r_o_hit;
    assign o_out.was_miss    = !r_o_hit;
    assign o_out.was_evict   = r_o_evict;
    assign o_out.hit_total   = r_hits;
    assign o_out.miss_total  = r_miss;
    assign o_out.evict_total = r_evic;
endmodule
`default_nettype wire

// ===== src/lru_set_assoc_cache_tags.sv =====
// top level of the lru set-associative cache tag store
`timescale 1ns / 1ps
`default_nettype none
// Tag store of a set-associative cache with least-recently-used replacement.
// Each access word carries a kind and a 48-bit byte address; fetch words are
// taken and dropped with no result, every other word yields one result word
// with hit, miss and eviction flags and the saturating running totals. A front
// stage splits the address into set and tag and pushes it into a two entry
// queue; the back reads the whole set row in one ram read, compares all ways
// at once and writes the row back. A hit, or a miss that finds a free way,
// is written back from the look state; a miss into a full set of several ways
// first runs a one-way-a-cycle stamp scan that picks the victim. After reset
// a clearing pass zeroes all 2^MAX_SET_BITS rows (at least 2) of the row ram,
// during which no access word is taken; configuration writes are always taken.
module lru_set_assoc_cache_tags #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    lsact_in_if.sink      i_in,
    lsact_cfg_if.sink     i_cfg,
    lsact_out_if.source   o_out
);
    // row ram needs at least one address bit
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ENT_W = 1 + SET_W + lsact_pkg::TAG_W;

    logic [2:0] r_set_bits;
    logic [3:0] r_ways_in_use;
    logic [4:0] r_block_bits;

    lsact_pkg::t_geom        w_geom;
    lsact_pkg::t_back_status w_status;
    logic                    w_push, w_full, w_pop, w_nonempty;
    logic [ENT_W-1:0]        w_entry, w_q_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= 3'd4;
            r_ways_in_use <= 4'd1;
            r_block_bits  <= 5'd4;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lsact_pkg::CFG_SET_BITS:    r_set_bits    <= i_cfg.data[2:0];
                lsact_pkg::CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg.data[3:0];
                lsact_pkg::CFG_BLOCK_BITS:  r_block_bits  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // clamp geometry to what the store holds
    always_comb begin
        w_geom.block_bits = r_block_bits;
        w_geom.set_bits   = r_set_bits;
        if (int'(r_set_bits) > MAX_SET_BITS) begin
            w_geom.set_bits = 3'(MAX_SET_BITS);
        end
        w_geom.ways = {1'b0, r_ways_in_use};
        if (r_ways_in_use == 4'd0) begin
            w_geom.ways = 5'd1;
        end else if (int'(r_ways_in_use) > MAX_WAYS) begin
            w_geom.ways = 5'(MAX_WAYS);
        end
    end

    lsact_front #(.SET_W(SET_W)) u_front (
        .i_in     (i_in),
        .i_geom   (w_geom),
        .i_status (w_status),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_entry  (w_entry)
    );

    lsact_queue #(.WIDTH(ENT_W)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_data     (w_entry),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_data     (w_q_data)
    );

    lsact_back #(.SET_W(SET_W), .MAX_WAYS(MAX_WAYS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (w_geom),
        .i_q_nonempty (w_nonempty),
        .i_q_data     (w_q_data),
        .o_pop        (w_pop),
        .o_status     (w_status),
        .o_out        (o_out)
    );
endmodule
`default_nettype wire

// ===== tb/lru_set_assoc_cache_tags_tb.sv =====
// self-checking testbench of the lru set-associative cache tag store
`timescale 1ns / 1ps
module lru_set_assoc_cache_tags_tb;

    localparam int SETS_MAX  = 64;
    localparam int WAYS_MAX  = 8;
    localparam int CYC_LIMIT = 1500000;

    typedef struct packed {
        logic [lsact_pkg::MODE_W-1:0] mode;
        logic [lsact_pkg::ADDR_W-1:0] address;
    } t_access;

    typedef struct packed {
        logic                          hit;
        logic                          miss;
        logic                          evict;
        logic [lsact_pkg::TOTAL_W-1:0] hits;
        logic [lsact_pkg::TOTAL_W-1:0] misses;
        logic [lsact_pkg::TOTAL_W-1:0] evicts;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    lsact_in_if  acc_ch ();
    lsact_out_if res_ch ();
    lsact_cfg_if cfg_ch ();

    lru_set_assoc_cache_tags DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (acc_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_out   (res_ch.source)
    );

    // predictor copy of the tag store
    logic                          pv_valid [SETS_MAX*WAYS_MAX];
    logic [lsact_pkg::TAG_W-1:0]   pv_tag   [SETS_MAX*WAYS_MAX];
    logic [lsact_pkg::STAMP_W-1:0] pv_stamp [SETS_MAX*WAYS_MAX];
    logic [lsact_pkg::STAMP_W-1:0] pv_clock;
    logic [lsact_pkg::TOTAL_W-1:0] pv_hits, pv_misses, pv_evicts;
    logic [2:0]                    pv_set_bits;
    logic [3:0]                    pv_ways;
    logic [4:0]                    pv_block_bits;

    t_access  pending_words [$];
    t_outcome expected_outcomes [$];
    int       err_count;
    int       cycle_count;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // no gap half of the time, else mostly a short gap, now and then a long one
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [lsact_pkg::TOTAL_W-1:0] bump_total(
            input logic [lsact_pkg::TOTAL_W-1:0] v);
        return (v == {lsact_pkg::TOTAL_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // lookup, fill or evict on the predictor copy; returns the expected result word
    function automatic t_outcome predict_lookup(input t_access a);
        t_outcome o;
        int sb, ways, set_idx, base, victim;
        logic [lsact_pkg::TAG_W-1:0] tag;
        bit hit, filled;
        sb = (pv_set_bits > 6) ? 6 : pv_set_bits;
        ways = (pv_ways == 0) ? 1 : ((pv_ways > 8) ? 8 : pv_ways);
        pv_clock = pv_clock + 1'b1;
        set_idx = int'((a.address >> pv_block_bits) & ((64'd1 << sb) - 1));
        tag = a.address >> (pv_block_bits + sb);
        base = set_idx * WAYS_MAX;
        hit = 0;
        filled = 0;
        o = '0;
        for (int w = 0; w < ways; w++) begin
            if (!hit && pv_valid[base+w] && pv_tag[base+w] == tag) begin
                hit = 1;
                pv_stamp[base+w] = pv_clock;
            end
        end
        if (hit) begin
            pv_hits = bump_total(pv_hits);
        end else begin
            pv_misses = bump_total(pv_misses);
            for (int w = 0; w < ways; w++) begin
                if (!filled && !pv_valid[base+w]) begin
                    pv_valid[base+w] = 1'b1;
                    pv_tag[base+w] = tag;
                    pv_stamp[base+w] = pv_clock;
                    filled = 1;
                end
            end
            if (!filled) begin
                victim = 0;
                for (int w = 1; w < ways; w++) begin
                    if (pv_stamp[base+w] < pv_stamp[base+victim]) victim = w;
                end
                pv_tag[base+victim] = tag;
                pv_stamp[base+victim] = pv_clock;
                pv_evicts = bump_total(pv_evicts);
                o.evict = 1'b1;
            end
        end
        if (a.mode == lsact_pkg::MODE_MODIFY) pv_hits = bump_total(pv_hits);
        o.hit = hit;
        o.miss = !hit;
        o.hits = pv_hits;
        o.misses = pv_misses;
        o.evicts = pv_evicts;
        return o;
    endfunction

    // driver: one access word at a time from the pending queue
    int in_gap;
    bit in_calm;
    bit in_acc = 1'b0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            acc_ch.valid <= 1'b0;
            in_gap = 0;
        end else if (acc_ch.valid && !in_acc) begin
            // hold the word until it is taken
        end else if (in_gap > 0) begin
            acc_ch.valid <= 1'b0;
            in_gap--;
        end else if (pending_words.size() > 0) begin
            t_access a;
            a = pending_words.pop_front();
            acc_ch.valid <= 1'b1;
            acc_ch.mode <= a.mode;
            acc_ch.address <= a.address;
            in_gap = pick_gap(in_calm);
        end else begin
            acc_ch.valid <= 1'b0;
        end
    end

    // predict at acceptance so the order matches the block
    always @(posedge i_clk) begin
        in_acc = i_rst_n && acc_ch.valid && acc_ch.ready;
        if (in_acc && acc_ch.mode != lsact_pkg::MODE_FETCH) begin
            t_access a;
            a.mode = acc_ch.mode;
            a.address = acc_ch.address;
            expected_outcomes.push_back(predict_lookup(a));
        end
    end

    // sink stall pattern
    int out_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            out_gap = 0;
        end else if (out_gap > 0) begin
            res_ch.ready <= 1'b0;
            out_gap--;
        end else begin
            res_ch.ready <= 1'b1;
            out_gap = pick_gap(in_calm);
        end
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result word hit=%0b miss=%0b evict=%0b",
                         $time, res_ch.was_hit, res_ch.was_miss, res_ch.was_evict);
                err_count++;
            end else begin
                t_outcome e, g;
                e = expected_outcomes.pop_front();
                g.hit = res_ch.was_hit;
                g.miss = res_ch.was_miss;
                g.evict = res_ch.was_evict;
                g.hits = res_ch.hit_total;
                g.misses = res_ch.miss_total;
                g.evicts = res_ch.evict_total;
                if (g.hit !== e.hit) begin
                    $display("%0t: was_hit exp %0b got %0b", $time, e.hit, g.hit);
                    err_count++;
                end
                if (g.miss !== e.miss) begin
                    $display("%0t: was_miss exp %0b got %0b", $time, e.miss, g.miss);
                    err_count++;
                end
                if (g.evict !== e.evict) begin
                    $display("%0t: was_evict exp %0b got %0b", $time, e.evict, g.evict);
                    err_count++;
                end
                if (g.hits !== e.hits) begin
                    $display("%0t: hit_total exp %0d got %0d", $time, e.hits, g.hits);
                    err_count++;
                end
                if (g.misses !== e.misses) begin
                    $display("%0t: miss_total exp %0d got %0d", $time, e.misses, g.misses);
                    err_count++;
                end
                if (g.evicts !== e.evicts) begin
                    $display("%0t: evict_total exp %0d got %0d", $time, e.evicts, g.evicts);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYC_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // configuration write, only while the block is idle
    task automatic write_reg(input logic [lsact_pkg::CFG_IDX_W-1:0] idx,
                             input logic [4:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            lsact_pkg::CFG_SET_BITS:    pv_set_bits = val[2:0];
            lsact_pkg::CFG_WAYS_IN_USE: pv_ways = val[3:0];
            lsact_pkg::CFG_BLOCK_BITS:  pv_block_bits = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || acc_ch.valid || expected_outcomes.size() > 0)
            @(posedge i_clk);
        // a trailing fetch word or a long scan may still be in flight
        repeat (40) @(posedge i_clk);
    endtask

    task automatic push_word(input logic [lsact_pkg::MODE_W-1:0] m,
                             input logic [lsact_pkg::ADDR_W-1:0] a);
        t_access w;
        w.mode = m;
        w.address = a;
        pending_words.push_back(w);
    endtask

    // random phase: addresses from a small pool of tags so sets fill and evict
    task automatic random_phase(input int n);
        logic [lsact_pkg::ADDR_W-1:0] a;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                a = lsact_pkg::ADDR_W'($urandom_range(0, 15)) << (pv_block_bits + 6);
                a = a | (lsact_pkg::ADDR_W'($urandom_range(0, 3)) << pv_block_bits);
                a = a | (lsact_pkg::ADDR_W'($urandom)
                         & ((lsact_pkg::ADDR_W'(1) << pv_block_bits) - 1));
            end else begin
                a = lsact_pkg::ADDR_W'({$urandom, $urandom});
            end
            push_word(lsact_pkg::MODE_W'($urandom_range(0, 3)), a);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        acc_ch.valid = 1'b0;
        acc_ch.mode = '0;
        acc_ch.address = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        err_count = 0;
        cycle_count = 0;
        in_calm = 0;
        foreach (pv_valid[k]) begin
            pv_valid[k] = 1'b0;
            pv_tag[k] = '0;
            pv_stamp[k] = '0;
        end
        pv_clock = '0;
        pv_hits = '0;
        pv_misses = '0;
        pv_evicts = '0;
        pv_set_bits = 3'd4;
        pv_ways = 4'd1;
        pv_block_bits = 5'd4;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset geometry, address extremes, every mode, conflicts
        push_word(lsact_pkg::MODE_LOAD, '0);
        push_word(lsact_pkg::MODE_LOAD, '0);
        push_word(lsact_pkg::MODE_STORE, {lsact_pkg::ADDR_W{1'b1}});
        push_word(lsact_pkg::MODE_MODIFY, {lsact_pkg::ADDR_W{1'b1}});
        push_word(lsact_pkg::MODE_FETCH, 48'h5555_5555_5555);
        push_word(lsact_pkg::MODE_STORE, 48'hAAAA_AAAA_AAAA);
        push_word(lsact_pkg::MODE_LOAD, 48'h0000_0000_0100);
        push_word(lsact_pkg::MODE_MODIFY, 48'h0000_0000_0200);
        push_word(lsact_pkg::MODE_FETCH, {lsact_pkg::ADDR_W{1'b1}});
        wait_drained();

        // eight ways, eviction and lru order
        write_reg(lsact_pkg::CFG_WAYS_IN_USE, 5'd8);
        write_reg(lsact_pkg::CFG_SET_BITS, 5'd0);
        write_reg(lsact_pkg::CFG_BLOCK_BITS, 5'd0);
        for (int i = 0; i < 9; i++) push_word(lsact_pkg::MODE_LOAD, lsact_pkg::ADDR_W'(i));
        push_word(lsact_pkg::MODE_MODIFY, 48'd1);
        push_word(lsact_pkg::MODE_LOAD, 48'd0);
        wait_drained();

        // out-of-range register values are clamped
        write_reg(lsact_pkg::CFG_SET_BITS, 5'd7);
        write_reg(lsact_pkg::CFG_WAYS_IN_USE, 5'd0);
        write_reg(lsact_pkg::CFG_BLOCK_BITS, 5'd31);
        push_word(lsact_pkg::MODE_LOAD, {lsact_pkg::ADDR_W{1'b1}});
        push_word(lsact_pkg::MODE_STORE, 48'h8000_0000_0000);
        wait_drained();
        write_reg(lsact_pkg::CFG_WAYS_IN_USE, 5'd15);
        write_reg(lsact_pkg::CFG_BLOCK_BITS, 5'd16);
        push_word(lsact_pkg::MODE_LOAD, 48'hFFFF_0000_0000);
        wait_drained();

        // random phases over a range of geometries, one calm stretch
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(lsact_pkg::CFG_SET_BITS,
                      5'((ph == 0) ? 0 : (ph == 1) ? 6 : $urandom_range(0, 7)));
            write_reg(lsact_pkg::CFG_WAYS_IN_USE,
                      5'((ph == 0) ? 8 : (ph == 1) ? 1 : $urandom_range(0, 15)));
            write_reg(lsact_pkg::CFG_BLOCK_BITS,
                      5'((ph == 2) ? 16 : $urandom_range(0, 31)));
            in_calm = (ph == 3);
            random_phase(250);
            wait_drained();
        end
        in_calm = 0;

        if (err_count == 0 && expected_outcomes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
